>>> hw/rtl/iqm_pkg.sv
// Package: shared constants and state type for the interquartile mean filter.
`default_nettype none
package iqm_pkg;

  localparam int CODE_W     = 12;
  localparam int WINDOW_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOADI,
    ST_GETI,
    ST_SCAN,
    ST_DECIDE,
    ST_DIV,
    ST_DONE
  } iqm_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/iqm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module iqm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/interquartile_mean_window_filter_unit.sv
// Top level: sliding-window interquartile mean filter over range sensor codes.
//
// Input channel: in_valid / in_stall with in_range_code (12-bit code, 1/8 inch).
// Result channel: out_valid / out_stall with out_trimmed_mean (12-bit code).
// One result request follows every accepted input request, in order.
// The window lives in a RAM of WINDOW entries. Each request overwrites the
// oldest entry, then every entry is ranked against all others by a sweep of
// RAM reads (one read per cycle), ranks in [WINDOW/4, ceil(3*WINDOW/4)) are
// summed, and the sum is divided by the constant count by a reciprocal
// multiplication. After accept, each window entry passes through the states
// LOADI, GETI, SCAN and DECIDE in turn, then DIV forms the quotient and
// DONE loads the output register. The next input request is taken the
// cycle after the result is placed in the output register, so a new
// request is never taken while the previous one is still in progress.
// A stalled result holds in the output register; a finished result waits
// in the core until the previous one is taken, and input stalls meanwhile.
// Reset (rst_n low, synchronous) clears the write pointer, the per-entry
// valid flags (entries never written read as zero) and all handshake state.
`default_nettype none
module interquartile_mean_window_filter_unit #(
  parameter int WINDOW = iqm_pkg::WINDOW_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [iqm_pkg::CODE_W-1:0]  in_range_code,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [iqm_pkg::CODE_W-1:0]  out_trimmed_mean
);
  import iqm_pkg::*;

  localparam int     IDX_W   = $clog2(WINDOW);
  localparam int     CNT_W   = $clog2(WINDOW + 1);
  localparam int     RANK_LO = WINDOW / 4;
  localparam int     RANK_HI = (3 * WINDOW + 3) / 4;
  localparam int     NSEL    = RANK_HI - RANK_LO;
  localparam int     SUM_W   = CODE_W + $clog2(WINDOW);
  localparam int     DIV_SH  = SUM_W + $clog2(NSEL);
  localparam int     MUL_W   = SUM_W + 2;
  localparam longint MUL_K   = ((longint'(1) << DIV_SH) + NSEL - 1) / NSEL;

  iqm_state_t state_r, state_nxt;

  logic [IDX_W-1:0]  wp_r, wp_nxt;
  logic [WINDOW-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_j_r, cmp_j_nxt;
  logic [CODE_W-1:0] vi_r, vi_nxt;
  logic [CNT_W-1:0]  rank_r, rank_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [CODE_W-1:0] out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              rd_ok_r;

  logic                    ram_we;
  logic [IDX_W-1:0]        raddr;
  logic [CODE_W-1:0]       rdata;
  logic [CODE_W-1:0]       rd_val;
  logic                    accept;
  logic                    out_load;
  logic                    in_range;
  logic [SUM_W-1:0]        sum_add;
  logic [SUM_W+MUL_W-1:0]  prod;

  iqm_ram #(
    .WIDTH (CODE_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_range_code),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign ram_we   = accept;
  assign rd_val   = rd_ok_r ? rdata : '0;
  assign in_range = (rank_r >= CNT_W'(RANK_LO)) && (rank_r < CNT_W'(RANK_HI));
  assign sum_add  = sum_r + (in_range ? SUM_W'(vi_r) : '0);
  assign prod     = sum_r * MUL_W'(MUL_K);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_trimmed_mean = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_LOADI;
      ST_LOADI:  state_nxt = ST_GETI;
      ST_GETI:   state_nxt = ST_SCAN;
      ST_SCAN:   if (!cmp_vld_r) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = (i_r == IDX_W'(WINDOW - 1)) ? ST_DIV : ST_LOADI;
      ST_DIV:    state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wp_nxt        = wp_r;
    valid_nxt     = valid_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_j_nxt     = cmp_j_r;
    vi_nxt        = vi_r;
    rank_nxt      = rank_r;
    sum_nxt       = sum_r;
    q_nxt         = q_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    raddr         = i_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          valid_nxt[wp_r] = 1'b1;
          wp_nxt          = (wp_r == IDX_W'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
          i_nxt           = '0;
          sum_nxt         = '0;
        end
      end
      ST_LOADI: begin
        raddr = i_r;
      end
      ST_GETI: begin
        vi_nxt      = rd_val;
        rank_nxt    = '0;
        raddr       = '0;
        j_nxt       = CNT_W'(1);
        cmp_vld_nxt = 1'b1;
        cmp_j_nxt   = '0;
      end
      ST_SCAN: begin
        raddr = j_r[IDX_W-1:0];
        if (cmp_vld_r) begin
          if ((rd_val < vi_r) || ((rd_val == vi_r) && (cmp_j_r < i_r))) begin
            rank_nxt = rank_r + 1'b1;
          end
        end
        cmp_vld_nxt = (j_r < CNT_W'(WINDOW));
        cmp_j_nxt   = j_r[IDX_W-1:0];
        if (j_r < CNT_W'(WINDOW)) begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        sum_nxt = sum_add;
        if (i_r == IDX_W'(WINDOW - 1)) begin
          i_nxt = '0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_DIV: begin
        q_nxt = SUM_W'(prod >> DIV_SH);
      end
      ST_DONE: begin
        if (out_load) begin
          out_nxt       = q_r[CODE_W-1:0];
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        raddr = i_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      valid_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      valid_r     <= valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ok_r     <= valid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    cmp_j_r <= cmp_j_nxt;
    vi_r    <= vi_nxt;
    rank_r  <= rank_nxt;
    sum_r   <= sum_nxt;
    q_r     <= q_nxt;
    out_r   <= out_nxt;
  end

endmodule
`default_nettype wire
